// ===== rtl/radar_presence_detector_unit_macros.svh =====
`ifndef RADAR_PRESENCE_DETECTOR_UNIT_MACROS_SVH
`define RADAR_PRESENCE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RPD_ASSERT_SAME(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Invariant that holds at every clock edge out of reset
`define RPD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ===== rtl/rpd_pkg.sv =====
package rpd_pkg;

  // Field widths
  localparam int IDX_W     = 5;
  localparam int MAG_W     = 32;
  localparam int STEP_W    = 11;
  localparam int THR_W     = 5;
  localparam int RANGE_W   = 16;
  localparam int CODE_W    = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ABSENT_THR  = 2'd0,
    CFG_RANGE_STEP  = 2'd1,
    CFG_VALID_LIMIT = 2'd2,
    CFG_REGION_MAX  = 2'd3
  } rpd_cfg_idx_t;

  // Configuration reset values
  localparam logic [THR_W-1:0]   ABSENT_THR_RST  = 5'd12;
  localparam logic [STEP_W-1:0]  RANGE_STEP_RST  = 11'd70;
  localparam logic [RANGE_W-1:0] VALID_LIMIT_RST = 16'd600;
  localparam logic [RANGE_W-1:0] REGION_MAX_RST  = 16'd500;

  // Drive actions
  localparam logic [CODE_W-1:0] ACT_NONE = 2'd0;
  localparam logic [CODE_W-1:0] ACT_OFF  = 2'd1;
  localparam logic [CODE_W-1:0] ACT_ON   = 2'd2;

  // Frame classes
  localparam logic [CODE_W-1:0] CLS_MOVING = 2'd0;
  localparam logic [CODE_W-1:0] CLS_STILL  = 2'd1;
  localparam logic [CODE_W-1:0] CLS_ABSENT = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] peak_range_index;
    logic [MAG_W-1:0] peak_magnitude;
    logic             presence_pin;
  } rpd_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]  drive_action;
    logic               presence_level;
    logic [RANGE_W-1:0] reported_range;
    logic [CODE_W-1:0]  frame_class;
  } rpd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DECIDE
  } rpd_state_t;

  // Motion threshold per range bin
  function automatic logic [RANGE_W-1:0] move_thr(input logic [5:0] bin);
    logic [RANGE_W-1:0] thr;
    case (bin)
      6'd0, 6'd1, 6'd2:        thr = 16'd2000;
      6'd3:                    thr = 16'd1500;
      6'd4, 6'd10:             thr = 16'd1300;
      6'd5, 6'd6:              thr = 16'd1200;
      6'd7, 6'd8, 6'd9:        thr = 16'd1600;
      6'd11:                   thr = 16'd500;
      6'd12:                   thr = 16'd400;
      6'd13, 6'd14:            thr = 16'd350;
      default:                 thr = 16'd730;
    endcase
    return thr;
  endfunction

endpackage

// ===== rtl/radar_presence_detector_unit.sv =====
// Sequencing: a frame that skips the averaging divider (still, absent or switching off)
//   goes from classification to the decision state, a moving frame runs the divider
//   in between; the input is stalled from acceptance until the result is registered,
//   so a new frame is taken only after the last one is through.
// Reset (rst_n, synchronous): registers take their default values, windows and
//   range history empty, output level off; no clearing pass is needed.
module radar_presence_detector_unit
  import rpd_pkg::*;
#(
  parameter int ABSENT_WINDOW      = 16,
  parameter int RANGE_WINDOW       = 8,
  parameter int RANGE_BINS         = 32,
  parameter int OUT_OF_RANGE_LIMIT = 100
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rpd_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rpd_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

`include "radar_presence_detector_unit_macros.svh"

  localparam int AP_W   = (ABSENT_WINDOW > 1) ? $clog2(ABSENT_WINDOW) : 1;
  localparam int AC_W   = $clog2(ABSENT_WINDOW + 1);
  localparam int CMP_W  = (AC_W > THR_W) ? AC_W : THR_W;
  localparam int RP_W   = (RANGE_WINDOW > 1) ? $clog2(RANGE_WINDOW) : 1;
  localparam int FILL_W = $clog2(RANGE_WINDOW + 1);
  localparam int SUM_W  = RANGE_W + FILL_W;
  localparam int OOR_W  = $clog2(OUT_OF_RANGE_LIMIT + 2);

  localparam logic [AP_W-1:0]   ABS_LAST  = AP_W'(ABSENT_WINDOW - 1);
  localparam logic [RP_W-1:0]   RNG_LAST  = RP_W'(RANGE_WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RANGE_WINDOW);
  localparam logic [OOR_W-1:0]  OOR_LIMIT = OOR_W'(OUT_OF_RANGE_LIMIT);
  localparam logic [6:0]        BIN_LAST  = 7'(RANGE_BINS - 1);

  // Sequencer
  rpd_state_t state_r, state_nxt;
  logic       class_en;
  logic       div_start;
  logic       held_load;
  logic       out_load;
  logic       out_free;

  // Configuration
  logic [THR_W-1:0]   thr_cfg_r;
  logic [STEP_W-1:0]  step_cfg_r;
  logic [RANGE_W-1:0] vlim_cfg_r;
  logic [RANGE_W-1:0] rmax_cfg_r;

  // Frame being worked on
  rpd_in_t           in_r;
  logic [CODE_W-1:0] cls_r;
  logic              off_r;

  // Absent window
  logic [ABSENT_WINDOW-1:0] abs_flags_r;
  logic [AP_W-1:0]          abs_pos_r;
  logic [AC_W-1:0]          abs_cnt_r;

  // Range ring and running sum
  logic [RANGE_W-1:0] hist_r [RANGE_WINDOW];
  logic [RP_W-1:0]    rng_pos_r;
  logic [FILL_W-1:0]  fill_r;
  logic [SUM_W-1:0]   sum_r;
  logic [RANGE_W-1:0] held_r;

  // Output decision state
  logic [OOR_W-1:0] oor_r;
  logic             level_r;
  logic             out_valid_r;
  rpd_out_t         out_r;

  // Classification datapath
  logic [6:0]          bin_ext;
  logic [6:0]          bin;
  logic [RANGE_W-1:0]  thr;
  logic [CODE_W-1:0]   cls;
  logic                moving;
  logic                absent;
  logic                old_flag;
  logic [AC_W-1:0]     abs_cnt_nxt;
  logic                go_off;
  logic [RANGE_W-1:0]  prod;
  logic [RANGE_W-1:0]  old_entry;
  logic [SUM_W-1:0]    sum_nxt;
  logic [FILL_W-1:0]   fill_nxt;
  logic [RP_W-1:0]     rng_pos_nxt;

  // Decision datapath
  logic [OOR_W-1:0]    oor_nxt;
  logic                level_nxt;
  rpd_out_t            out_nxt;

  // Divider hookup
  logic                div_done;
  logic [RANGE_W-1:0]  div_quo;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CLASS;
      ST_CLASS:    state_nxt = (go_off || !moving) ? ST_DECIDE : ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = ST_DECIDE;
      ST_DECIDE:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer strobes
  always_comb begin
    in_stall  = 1'b1;
    class_en  = 1'b0;
    div_start = 1'b0;
    held_load = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:     in_stall  = 1'b0;
      ST_CLASS:    class_en  = 1'b1;
      ST_DIV_GO:   div_start = 1'b1;
      ST_DIV_WAIT: held_load = div_done;
      ST_DECIDE:   out_load  = out_free;
      default:     in_stall  = 1'b1;
    endcase
  end

  // Classify the frame and update both windows
  always_comb begin
    bin_ext = {2'b00, in_r.peak_range_index};
    bin     = (bin_ext > BIN_LAST) ? BIN_LAST : bin_ext;
    thr     = move_thr(bin[5:0]);
    if (in_r.peak_magnitude > {16'd0, thr}) begin
      cls = CLS_MOVING;
    end else if (in_r.presence_pin) begin
      cls = CLS_STILL;
    end else begin
      cls = CLS_ABSENT;
    end
    moving   = (cls == CLS_MOVING);
    absent   = (cls == CLS_ABSENT);
    old_flag = abs_flags_r[abs_pos_r];

    // Running count of absent flags: zero on motion, else drop the overwritten one, add the new one
    if (moving) begin
      abs_cnt_nxt = '0;
    end else if (old_flag && !absent) begin
      abs_cnt_nxt = abs_cnt_r - 1'b1;
    end else if (!old_flag && absent) begin
      abs_cnt_nxt = abs_cnt_r + 1'b1;
    end else begin
      abs_cnt_nxt = abs_cnt_r;
    end
    go_off = (CMP_W'(abs_cnt_nxt) >= CMP_W'(thr_cfg_r));

    // Ring entries past the fill count read as empty
    prod        = RANGE_W'(in_r.peak_range_index) * RANGE_W'(step_cfg_r);
    old_entry   = (fill_r == FILL_FULL) ? hist_r[rng_pos_r] : '0;
    sum_nxt     = sum_r - SUM_W'(old_entry) + SUM_W'(prod);
    fill_nxt    = (fill_r == FILL_FULL) ? fill_r : fill_r + 1'b1;
    rng_pos_nxt = (rng_pos_r == RNG_LAST) ? '0 : rng_pos_r + 1'b1;
  end

  // Decide the drive action from the held range
  always_comb begin
    if (held_r > vlim_cfg_r) begin
      oor_nxt = (oor_r <= OOR_LIMIT) ? oor_r + 1'b1 : oor_r;
    end else begin
      oor_nxt = '0;
    end
    out_nxt.frame_class    = cls_r;
    out_nxt.reported_range = '0;
    level_nxt              = level_r;
    if (off_r) begin
      oor_nxt              = oor_r;
      level_nxt            = 1'b0;
      out_nxt.drive_action = ACT_OFF;
    end else if (held_r == '0) begin
      out_nxt.drive_action = ACT_NONE;
    end else if (oor_nxt > OOR_LIMIT) begin
      level_nxt            = 1'b0;
      out_nxt.drive_action = ACT_OFF;
    end else begin
      level_nxt              = 1'b1;
      out_nxt.drive_action   = ACT_ON;
      out_nxt.reported_range = (held_r > rmax_cfg_r) ? rmax_cfg_r : held_r;
    end
    out_nxt.presence_level = level_nxt;
  end

  // Averaging divider: running sum over fill count
  rpd_divider #(
    .DEN_W(FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_cfg_r   <= ABSENT_THR_RST;
      step_cfg_r  <= RANGE_STEP_RST;
      vlim_cfg_r  <= VALID_LIMIT_RST;
      rmax_cfg_r  <= REGION_MAX_RST;
      abs_flags_r <= '0;
      abs_pos_r   <= '0;
      abs_cnt_r   <= '0;
      rng_pos_r   <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      held_r      <= '0;
      oor_r       <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Take register writes
      if (cfg_we) begin
        case (rpd_cfg_idx_t'(cfg_index))
          CFG_ABSENT_THR:  thr_cfg_r  <= cfg_wdata[THR_W-1:0];
          CFG_RANGE_STEP:  step_cfg_r <= cfg_wdata[STEP_W-1:0];
          CFG_VALID_LIMIT: vlim_cfg_r <= cfg_wdata;
          CFG_REGION_MAX:  rmax_cfg_r <= cfg_wdata;
          default:         thr_cfg_r  <= thr_cfg_r;
        endcase
      end

      // Record the absent flag, clear the window on motion
      if (class_en) begin
        if (moving) begin
          abs_flags_r <= '0;
        end else begin
          abs_flags_r[abs_pos_r] <= absent;
        end
        abs_pos_r <= (abs_pos_r == ABS_LAST) ? '0 : abs_pos_r + 1'b1;
        abs_cnt_r <= abs_cnt_nxt;

        // Drop range history on switch-off, else advance the ring on motion
        if (go_off) begin
          rng_pos_r <= '0;
          fill_r    <= '0;
          sum_r     <= '0;
          held_r    <= '0;
        end else if (moving) begin
          rng_pos_r <= rng_pos_nxt;
          fill_r    <= fill_nxt;
          sum_r     <= sum_nxt;
        end
      end

      if (held_load) begin
        held_r <= div_quo;
      end

      // Commit the decision with the result beat
      if (out_load) begin
        oor_r   <= oor_nxt;
        level_r <= level_nxt;
      end
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (class_en) begin
      cls_r <= cls;
      off_r <= go_off;
    end
    if (class_en && !go_off && moving) begin
      hist_r[rng_pos_r] <= prod;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Running absent count tracks the flags it summarizes
  `RPD_ASSERT_ALWAYS(a_absent_count, abs_cnt_r == $countones(abs_flags_r), "absent count drift")
  // Until the ring is full the write position equals the fill count
  `RPD_ASSERT_SAME(a_ring_fill, fill_r != FILL_FULL, FILL_W'(rng_pos_r) == fill_r, "ring fill mismatch")
  // A switching beat reports the level it switched to
  `RPD_ASSERT_SAME(a_level_match, out_valid_r && (out_r.drive_action != ACT_NONE), out_r.presence_level == (out_r.drive_action == ACT_ON), "level disagrees with action")
  // Range is reported only on switch-on
  `RPD_ASSERT_SAME(a_range_on_only, out_valid_r && (out_r.drive_action != ACT_ON), out_r.reported_range == '0, "range reported without switch-on")

endmodule

// ===== rtl/rpd_divider.sv =====
module rpd_divider
  import rpd_pkg::*;
#(
  parameter int DEN_W = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DEN_W+RANGE_W-1:0] dividend,
  input  logic [DEN_W-1:0]         divisor,
  output logic                     done,
  output logic [RANGE_W-1:0]       quotient
);

  localparam int STEP_CNT_W = $clog2(RANGE_W);
  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(RANGE_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_CNT_W-1:0] step_r;
  logic [DEN_W-1:0]      rem_r;
  logic [DEN_W-1:0]      den_r;
  logic [RANGE_W-1:0]    quo_r;

  logic [DEN_W:0]        trial;
  logic                  fits;
  logic [DEN_W-1:0]      rem_nxt;
  logic [RANGE_W-1:0]    quo_nxt;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[RANGE_W-1]};
    fits    = (trial >= {1'b0, den_r});
    rem_nxt = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    quo_nxt = {quo_r[RANGE_W-2:0], fits};
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load operands; upper dividend bits start below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DEN_W+RANGE_W-1:RANGE_W];
      quo_r <= dividend[RANGE_W-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== tb/rpd_frame_checker.sv =====
module rpd_frame_checker
  import rpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  rpd_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  rpd_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AWIN       = 16;
  localparam int RWIN       = 8;
  localparam int OOR_LIMIT  = 100;

  // Register copies
  logic [THR_W-1:0]   absent_thr_q;
  logic [STEP_W-1:0]  step_q;
  logic [RANGE_W-1:0] limit_q;
  logic [RANGE_W-1:0] region_max_q;

  // Detector state
  logic [AWIN-1:0]    absent_flags_q;
  logic [3:0]         absent_pos_q;
  logic [RANGE_W-1:0] range_ring [RWIN];
  logic [2:0]         ring_pos_q;
  int unsigned        ring_fill_q;
  logic [RANGE_W-1:0] held_range_q;
  int unsigned        oor_count_q;
  logic               level_q;

  rpd_out_t decision_q[$];
  int       mismatch_total = 0;
  int       beats_seen = 0;

  assign fail_count = mismatch_total;
  initial pending_count = 0;

  // Motion floor per range bin; bins 15 and up share one value
  function automatic logic [RANGE_W-1:0] motion_threshold(input logic [IDX_W-1:0] bin);
    if (bin >= 15) return 16'd730;
    case (bin)
      0, 1, 2: return 16'd2000;
      3:       return 16'd1500;
      4, 10:   return 16'd1300;
      5, 6:    return 16'd1200;
      11:      return 16'd500;
      12:      return 16'd400;
      13, 14:  return 16'd350;
      default: return 16'd1600;
    endcase
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < RWIN; i++) range_ring[i] = '0;
    ring_pos_q = '0;
    ring_fill_q = 0;
    held_range_q = '0;
  endfunction

  function automatic void reset_detector();
    absent_thr_q = ABSENT_THR_RST;
    step_q = RANGE_STEP_RST;
    limit_q = VALID_LIMIT_RST;
    region_max_q = REGION_MAX_RST;
    absent_flags_q = '0;
    absent_pos_q = '0;
    clear_history();
    oor_count_q = 0;
    level_q = 1'b0;
  endfunction

  // Advance the detector by one frame and return its decision
  function automatic rpd_out_t decide_frame(input rpd_in_t f);
    rpd_out_t    d;
    int unsigned sum;
    int unsigned prod;
    int unsigned rng;
    d = '0;
    if (f.peak_magnitude > motion_threshold(f.peak_range_index))
      d.frame_class = CLS_MOVING;
    else if (f.presence_pin)
      d.frame_class = CLS_STILL;
    else
      d.frame_class = CLS_ABSENT;

    absent_flags_q[absent_pos_q] = (d.frame_class == CLS_ABSENT);
    absent_pos_q = absent_pos_q + 4'd1;
    if (d.frame_class == CLS_MOVING) absent_flags_q = '0;

    if ($countones(absent_flags_q) >= absent_thr_q) begin
      level_q = 1'b0;
      d.drive_action = ACT_OFF;
      clear_history();
    end else begin
      // Push the new range and average the filled part of the ring
      if (d.frame_class == CLS_MOVING) begin
        prod = f.peak_range_index * step_q;
        range_ring[ring_pos_q] = prod[15:0];
        ring_pos_q = ring_pos_q + 3'd1;
        if (ring_fill_q < RWIN) ring_fill_q++;
        sum = 0;
        for (int i = 0; i < ring_fill_q; i++) sum += range_ring[i];
        held_range_q = 16'(sum / ring_fill_q);
      end
      rng = held_range_q;
      if (rng > limit_q) begin
        if (oor_count_q <= OOR_LIMIT) oor_count_q++;
      end else begin
        oor_count_q = 0;
      end
      if (rng == 0) begin
        d.drive_action = ACT_NONE;
      end else if (oor_count_q > OOR_LIMIT) begin
        level_q = 1'b0;
        d.drive_action = ACT_OFF;
      end else begin
        if (rng > region_max_q) rng = region_max_q;
        level_q = 1'b1;
        d.drive_action = ACT_ON;
        d.reported_range = 16'(rng);
      end
    end
    d.presence_level = level_q;
    return d;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      mismatch_total++;
      $display("%0t: result beat %0d %s expected %0d got %0d",
               $time, beats_seen, name, exp_v, got_v);
    end
  endtask

  // Track registers, predict accepted frames, compare accepted results
  always @(posedge clk) begin
    rpd_out_t want;
    if (!rst_n) begin
      reset_detector();
      decision_q.delete();
    end else begin
      if (cfg_we) begin
        case (rpd_cfg_idx_t'(cfg_index))
          CFG_ABSENT_THR:  absent_thr_q = cfg_wdata[THR_W-1:0];
          CFG_RANGE_STEP:  step_q = cfg_wdata[STEP_W-1:0];
          CFG_VALID_LIMIT: limit_q = cfg_wdata;
          CFG_REGION_MAX:  region_max_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decision_q.push_back(decide_frame(in_data));
      if (out_valid && !out_stall) begin
        if (decision_q.size() == 0) begin
          mismatch_total++;
          $display("%0t: result beat %0d arrived with nothing expected, got %h",
                   $time, beats_seen, out_data);
        end else begin
          want = decision_q.pop_front();
          check_field("drive_action", want.drive_action, out_data.drive_action);
          check_field("presence_level", want.presence_level, out_data.presence_level);
          check_field("reported_range", want.reported_range, out_data.reported_range);
          check_field("frame_class", want.frame_class, out_data.frame_class);
        end
        beats_seen++;
      end
    end
    pending_count <= decision_q.size();
  end

endmodule

// ===== tb/tb_radar_presence_detector_unit.sv =====
module tb_radar_presence_detector_unit
  import rpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  typedef enum {SEG_MOVING, SEG_STILL, SEG_ABSENT, SEG_NOISE} segment_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  rpd_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rpd_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ABSENT_THR;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  radar_presence_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rpd_frame_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Stall the result channel: long hold-off on request, else random
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, pending_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one frame beat and hold it until accepted
  task automatic send_frame(input logic [IDX_W-1:0] idx, input logic [MAG_W-1:0] mag,
                            input logic pin);
    rpd_in_t beat;
    beat.peak_range_index = idx;
    beat.peak_magnitude = mag;
    beat.presence_pin = pin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] vals [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= rpd_cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_kind(input segment_kind_t kind);
    logic [IDX_W-1:0] idx;
    logic [MAG_W-1:0] thr;
    logic [MAG_W-1:0] mag;
    idx = $urandom_range(31);
    case (kind)
      SEG_MOVING: begin
        if ($urandom_range(1)) idx = $urandom_range(16, 31);
        thr = move_thr({1'b0, idx});
        case ($urandom_range(3))
          0:       mag = thr + 1;
          1:       mag = thr + 1 + $urandom_range(100000);
          default: mag = ($urandom > thr) ? $urandom : thr + 2;
        endcase
        send_frame(idx, mag, $urandom_range(1));
      end
      SEG_STILL, SEG_ABSENT: begin
        thr = move_thr({1'b0, idx});
        mag = ($urandom_range(3) == 0) ? thr : $urandom_range(thr);
        send_frame(idx, mag, kind == SEG_STILL);
      end
      default: begin
        mag = $urandom >> $urandom_range(31);
        send_frame(idx, mag, $urandom_range(1));
      end
    endcase
  endtask

  // Program one register setting, then run well-formed segments with some noise
  task automatic run_phase(input int p);
    logic [CFG_W-1:0] regs [4];
    int count;
    int hold_at;
    int pause_at;
    int sent;
    int len;
    int r;
    segment_kind_t kind;
    hold_at = -1;
    pause_at = -1;
    case (p)
      0: begin
        regs = '{16'd16, 16'd2047, 16'd65535, 16'd65535};
        count = 350;
        send_idle_pct = 0;
        stall_pct <= 0;
      end
      1: begin
        regs = '{16'd0, 16'd1, 16'd0, 16'd0};
        count = 150;
        send_idle_pct = 46;
        stall_pct <= 0;
      end
      2: begin
        regs = '{16'd3, 16'd0, 16'd200, 16'd1000};
        count = 250;
        send_idle_pct = 0;
        stall_pct <= 46;
      end
      4: begin
        regs = '{16'd20, 16'd150, 16'd1500, 16'd2500};
        count = 400;
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_at = 100;
        pause_at = 300;
      end
      default: begin
        regs[0] = $urandom_range(1, 16);
        regs[1] = $urandom_range(1, 2047);
        regs[2] = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(8000);
        regs[3] = $urandom_range(65535);
        count = 400;
        send_idle_pct = 25;
        stall_pct <= 25;
      end
    endcase
    drain();
    program_regs(regs);
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 35) begin
        kind = SEG_MOVING;
        len = $urandom_range(1, 10);
      end else if (r < 60) begin
        kind = SEG_STILL;
        len = ($urandom_range(7) == 0) ? $urandom_range(100, 115) : $urandom_range(1, 20);
      end else if (r < 82) begin
        kind = SEG_ABSENT;
        len = $urandom_range(1, 20);
      end else begin
        kind = SEG_NOISE;
        len = $urandom_range(1, 6);
      end
      for (int k = 0; k < len && sent < count; k++) begin
        if (sent == hold_at) hold_req <= hold_req + 1;
        if (sent == pause_at) drain();
        send_kind(kind);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames on the reset register values
    send_frame(5'd0, 32'd2001, 1'b0);
    send_frame(5'd0, 32'd2000, 1'b1);
    send_frame(5'd31, 32'hFFFF_FFFF, 1'b1);
    send_frame(5'd13, 32'd351, 1'b0);
    send_frame(5'd13, 32'd350, 1'b0);
    send_frame(5'd11, 32'd500, 1'b1);
    send_frame(5'd15, 32'd731, 1'b0);
    send_frame(5'd15, 32'd730, 1'b1);
    send_frame(5'd1, 32'd0, 1'b1);
    for (int i = 0; i < 12; i++) send_frame(5'd2, 32'd0, 1'b0);
    send_frame(5'd20, 32'd0, 1'b1);
    send_frame(5'd4, 32'h8000_0000, 1'b0);

    for (int p = 0; p < 6; p++) run_phase(p);

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
